FILE: design/bbo_pkg.sv
// Shared types, constants and helpers for the bitmap bit-operations engine.
// Used by bbo_store and bitmap_bit_ops_engine; no dependencies.

package bbo_pkg;

   localparam int WORD_BITS = 64;
   localparam int WORDS     = 64;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int ADDR_W    = $clog2(WORDS);
   localparam int INDEX_W   = 12;
   localparam int OPCODE_W  = 4;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = 7;

   localparam logic [OPCODE_W-1:0] OP_SET         = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR       = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_TOGGLE      = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_TEST_SET    = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_TEST_CLEAR  = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_TEST_TOGGLE = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_GET         = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_FIND_SET    = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_FIND_ZERO   = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_ALL   = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic [CNT_W-1:0] WORDS_RESET = 7'd64;

   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 clr_en;
      logic [CNT_W-1:0]     clr_words;
   } mem_req_type;

   // Position of the lowest set bit; isolate it, then encode the one-hot.
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] lsb;
      logic [BIT_W-1:0]     enc;
      lsb = x & (~x + WORD_BITS'(1));
      enc = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lsb[i]) begin
            enc = enc | BIT_W'(i);
         end
      end
      return enc;
   endfunction

endpackage

FILE: design/bbo_store.sv
// Bitmap word store: synchronous memory with one read and one write port and
// registered read, plus per-word valid bits so that reset and clear-all need no
// clearing pass. Depends on bbo_pkg.

module bbo_store (
   input  logic                          clock,
   input  logic                          reset,
   input  bbo_pkg::mem_req_type          mem_req,
   output logic [bbo_pkg::WORD_BITS-1:0] rd_word
);
   import bbo_pkg::*;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORDS-1:0]     valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   // An invalid word reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_req.rd_en) begin
            rd_vld_ff <= valid_ff[mem_req.rd_addr];
         end
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.clr_en) begin
            for (int w = 0; w < WORDS; w++) begin
               if (CNT_W'(w) < mem_req.clr_words) begin
                  valid_ff[w] <= 1'b0;
               end
            end
         end
      end
   end

   assign rd_word = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: design/bitmap_bit_ops_engine.sv
// Top level of the bitmap bit-operations engine: request FSM, word scan,
// result register and the words-in-use register. Depends on bbo_pkg, bbo_store.

// One request is worked at a time. Set, clear, toggle, their test forms, get,
// clear-all and out-of-range requests: the accept cycle issues the word read; in
// execute, once the result register is free, the modified word is written back
// (set, clear, toggle and test forms in range only; clear-all clears the valid
// bits) and the result register is loaded. A find reads one word per cycle via
// the single memory read port, from the start word up to the hit or the last
// word in use (at most 64). The result register frees the request side: a new
// request is taken once the previous one has left its result, even if that
// result is still stalled. The store is cleared at reset by per-word valid bits,
// with no clearing pass; words_in_use resets to 64 and must be written through
// the csr channel only while the engine is idle; the block does not enforce it.

module bitmap_bit_ops_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bbo_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [bbo_pkg::INDEX_W-1:0]  req_bit_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bbo_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_bit_value,
   output logic [bbo_pkg::INDEX_W-1:0]  rsp_found_index,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bbo_pkg::CNT_W-1:0]    csr_data
);
   import bbo_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic [OPCODE_W-1:0]  op_ff, op_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic                 first_ff, first_in;
   logic [CNT_W-1:0]     words_in_use_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_bit_ff, rsp_bit_in;
   logic [INDEX_W-1:0]   rsp_found_ff, rsp_found_in;

   mem_req_type          mem_req;
   logic [WORD_BITS-1:0] rd_word;

   logic                 accept;
   logic                 out_free;
   logic [CNT_W-1:0]     active;
   logic                 out_of_range;
   logic                 last_word;
   logic [ADDR_W-1:0]    word_next;
   logic [BIT_W-1:0]     bit_sel;
   logic                 old_bit;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] cand;
   logic                 hit;
   logic                 finish;
   logic                 scan_adv;

   bbo_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign active       = (words_in_use_ff > CNT_W'(WORDS)) ? CNT_W'(WORDS) : words_in_use_ff;
   assign out_of_range = {1'b0, idx_ff[INDEX_W-1:BIT_W]} >= active;
   assign last_word    = (CNT_W'(word_ff) + CNT_W'(1)) >= active;
   assign word_next    = word_ff + ADDR_W'(1);
   assign bit_sel      = idx_ff[BIT_W-1:0];
   assign old_bit      = rd_word[bit_sel];
   assign bit_mask     = WORD_BITS'(1) << bit_sel;

   always_comb begin
      case (op_ff) inside
         OP_SET, OP_TEST_SET:       new_word = rd_word | bit_mask;
         OP_CLEAR, OP_TEST_CLEAR:   new_word = rd_word & ~bit_mask;
         OP_TOGGLE, OP_TEST_TOGGLE: new_word = rd_word ^ bit_mask;
         default:                   new_word = rd_word;
      endcase
   end

   // Candidate bits of the current word; the start word drops bits below the index.
   assign cand = ((op_ff == OP_FIND_SET) ? rd_word : ~rd_word)
               & (first_ff ? ({WORD_BITS{1'b1}} << bit_sel) : {WORD_BITS{1'b1}});
   assign hit  = |cand;

   always_comb begin
      finish        = 1'b0;
      scan_adv      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_bit_in    = 1'b0;
      rsp_found_in  = '0;

      mem_req           = '0;
      mem_req.rd_en     = accept;
      mem_req.rd_addr   = req_bit_index[INDEX_W-1:BIT_W];
      mem_req.wr_addr   = word_ff;
      mem_req.wr_data   = new_word;
      mem_req.clr_words = active;

      if (state_ff == ST_EXEC) begin
         case (op_ff) inside
            OP_SET, OP_CLEAR, OP_TOGGLE,
            OP_TEST_SET, OP_TEST_CLEAR, OP_TEST_TOGGLE, OP_GET: begin
               finish = out_free;
               if (out_of_range) begin
                  rsp_status_in = STATUS_RANGE;
               end else begin
                  rsp_bit_in     = (op_ff >= OP_TEST_SET) ? old_bit : 1'b0;
                  mem_req.wr_en  = out_free && (op_ff != OP_GET);
               end
            end
            OP_FIND_SET, OP_FIND_ZERO: begin
               if (first_ff && out_of_range) begin
                  finish        = out_free;
                  rsp_status_in = STATUS_RANGE;
               end else if (hit) begin
                  finish       = out_free;
                  rsp_found_in = {word_ff, lowest_set(cand)};
               end else if (last_word) begin
                  finish        = out_free;
                  rsp_status_in = STATUS_NOT_FOUND;
               end else begin
                  // advance to the next word; reads overlap the scan
                  scan_adv        = 1'b1;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = word_next;
               end
            end
            OP_CLEAR_ALL: begin
               finish         = out_free;
               mem_req.clr_en = out_free;
            end
            default: begin
               finish = out_free;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      word_in  = word_ff;
      first_in = first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               op_in    = req_opcode;
               idx_in   = req_bit_index;
               word_in  = req_bit_index[INDEX_W-1:BIT_W];
               first_in = 1'b1;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               state_in = ST_IDLE;
            end else if (scan_adv) begin
               word_in  = word_next;
               first_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         words_in_use_ff <= WORDS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            words_in_use_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      word_ff  <= word_in;
      first_ff <= first_in;
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_bit_ff    <= rsp_bit_in;
         rsp_found_ff  <= rsp_found_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_bit_value   = rsp_bit_ff;
   assign rsp_found_index = rsp_found_ff;

   a_wr_only_bit_ops: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == ST_EXEC) && (op_ff <= OP_TEST_TOGGLE) && !out_of_range)
      else $error("store write outside a bit operation");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("result loaded outside execute");

   a_not_found_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_RANGE))
         |-> (rsp_found_index == '0) && !rsp_bit_value)
      else $error("error result carries data");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      scan_adv |=> (CNT_W'(word_ff) < active) && !first_ff)
      else $error("scan left the words in use");

endmodule
